// ===== sv/qslerp_pkg.sv =====
package qslerp_pkg;

  localparam int FRAC             = 14;  // fraction bits of components and blend
  localparam int ANGLE_ITERATIONS = 16;  // default CORDIC step count
  localparam int UNIT             = 30;  // internal unit is 2^30

  localparam int CW   = 16;         // component width
  localparam int QW   = CW + 1;     // component after exact negation
  localparam int TW   = 15;         // blend width
  localparam int DW   = UNIT + 1;   // clamped dot product in Q30
  localparam int RW   = 2*UNIT + 1; // sqrt radicand
  localparam int SW   = UNIT + 1;   // sqrt result
  localparam int VW   = UNIT + 4;   // CORDIC x/y
  localparam int ZW   = 27;         // CORDIC angle accumulator, Q24 rad
  localparam int AW   = 25;         // non-negative angle
  localparam int WW   = 34;         // weight, Q30, saturated to +-4
  localparam int DENW = UNIT + 2;   // sine divisor
  localparam int LW   = 10;         // small-angle limit register

  localparam logic [TW-1:0] ONE_T     = TW'(64'(1) << FRAC);
  localparam logic [LW-1:0] LIMIT_RST = LW'(17);

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [QW-1:0] qcomp_t;
  typedef logic [TW-1:0]        blend_t;

  // per-item data carried alongside the angle math
  typedef struct packed {
    logic          lin;  // use linear weights
    blend_t        t;
    qcomp_t [3:0]  q;
    comp_t  [3:0]  p;
  } side_t;

  // atan(2^-i) in Q24 rad
  function automatic logic [ZW-1:0] arc_step(input int i);
    logic [ZW-1:0] r;
    unique case (i)
      0: r = ZW'(13176795);
      1: r = ZW'(7778716);
      2: r = ZW'(4110060);
      3: r = ZW'(2086331);
      4: r = ZW'(1047214);
      5: r = ZW'(524117);
      6: r = ZW'(262123);
      7: r = ZW'(131069);
      8: r = ZW'(65536);
      9: r = ZW'(32768);
      default: r = (i <= 24) ? ZW'(64'(1) << (24 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/quaternion_slerp.sv =====
// Quaternion slerp, fully pipelined.
// s_axis carries one interpolation per transaction: two unit quaternions in
// signed Q2.14 and a blend factor t in unsigned Q1.14 (above one is taken
// as one). m_axis returns the blended quaternion in Q2.14, saturated to +-1,
// not renormalized. cfg_valid/cfg_data write the 10-bit small-angle limit
// (Q24 rad); at or below it the weights are 1-t and t. cfg_ready is always
// high; write it only while nothing is in flight.
// Stages in order: dot product, square root (one root bit per stage), angle
// CORDIC (ANGLE_ITERATIONS steps), one angle-scaling stage, sine CORDICs
// (ANGLE_ITERATIONS steps each), weight dividers (one quotient bit per stage)
// and blend. One transaction per cycle while m_axis is not stalled. A stall
// on m_axis freezes every stage together and drops s_axis_tready; nothing is
// lost or repeated. Reset clears the valid bits and sets the limit to 17.
module quaternion_slerp #(
  parameter int ANGLE_ITERATIONS = qslerp_pkg::ANGLE_ITERATIONS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // first_w, first_x, first_y, first_z, second_w, second_x, second_y,
  // second_z (16 each), blend (15), one pad bit
  input  logic [143:0]              s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // out_w, out_x, out_y, out_z (16 each)
  output logic [63:0]               m_axis_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [qslerp_pkg::LW-1:0] cfg_data
);
  import qslerp_pkg::*;

  localparam int SIDEW = $bits(side_t);

  logic                 en;
  logic [LW-1:0]        limit;

  comp_t [3:0]          in_p, in_q;
  blend_t               in_t;

  logic                 fr_valid;
  logic [DW-1:0]        fr_d30;
  logic [RW-1:0]        fr_rad;
  side_t                fr_side;

  logic                 sq_valid;
  logic [SW-1:0]        sq_root;
  logic [DW+SIDEW-1:0]  sq_side;

  logic                 vc_valid;
  logic [AW-1:0]        vc_theta;
  side_t                vc_side;

  logic                 ang_valid;
  logic signed [ZW-1:0] ang_theta, ang_a1, ang_a2;
  side_t                ang_side;
  side_t                ang_side_next;

  logic                 rt_valid;
  logic signed [VW-1:0] rt_st, rt_s1, rt_s2;
  side_t                rt_side;
  side_t                dv_in_side;

  logic                 dv_valid;
  logic signed [WW-1:0] dv_w1, dv_w2;
  side_t                dv_side;

  comp_t [3:0]          out_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RST;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  assign in_p = s_axis_tdata[63:0];
  assign in_q = s_axis_tdata[127:64];
  assign in_t = s_axis_tdata[142:128];

  qslerp_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_axis_tvalid),
    .in_p(in_p), .in_q(in_q), .in_t(in_t),
    .out_valid(fr_valid), .out_d30(fr_d30), .out_rad(fr_rad), .out_side(fr_side)
  );

  qslerp_isqrt #(.SIDE_W(DW + SIDEW)) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(fr_valid),
    .in_rad(fr_rad), .in_side({fr_d30, fr_side}),
    .out_valid(sq_valid), .out_root(sq_root), .out_side(sq_side)
  );

  qslerp_vec #(.ITERS(ANGLE_ITERATIONS), .SIDE_W(SIDEW)) u_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_valid),
    .in_x(sq_side[DW+SIDEW-1:SIDEW]), .in_y(sq_root), .in_side(sq_side[SIDEW-1:0]),
    .out_valid(vc_valid), .out_theta(vc_theta), .out_side(vc_side)
  );

  // partial angles t*theta and (1-t)*theta, small-angle decision
  always_comb begin
    ang_side_next     = vc_side;
    ang_side_next.lin = 64'(vc_theta) <= 64'(limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else if (en) begin
      ang_valid <= vc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_theta <= ZW'(vc_theta);
      ang_a2    <= ZW'((64'(vc_side.t) * 64'(vc_theta)) >> FRAC);
      ang_a1    <= ZW'((64'(ONE_T - vc_side.t) * 64'(vc_theta)) >> FRAC);
      ang_side  <= ang_side_next;
    end
  end

  qslerp_rot #(.ITERS(ANGLE_ITERATIONS), .SIDE_W(SIDEW)) u_rot_theta (
    .clk(clk), .rst(rst), .en(en), .in_valid(ang_valid),
    .in_z(ang_theta), .in_side(ang_side),
    .out_valid(rt_valid), .out_y(rt_st), .out_side(rt_side)
  );

  qslerp_rot #(.ITERS(ANGLE_ITERATIONS), .SIDE_W(1)) u_rot_a1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(ang_valid),
    .in_z(ang_a1), .in_side(1'b0),
    .out_valid(), .out_y(rt_s1), .out_side()
  );

  qslerp_rot #(.ITERS(ANGLE_ITERATIONS), .SIDE_W(1)) u_rot_a2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(ang_valid),
    .in_z(ang_a2), .in_side(1'b0),
    .out_valid(), .out_y(rt_s2), .out_side()
  );

  // a vanishing sine falls back to linear weights
  always_comb begin
    dv_in_side     = rt_side;
    dv_in_side.lin = rt_side.lin || (rt_st <= 0);
  end

  qslerp_div #(.SIDE_W(SIDEW)) u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(rt_valid),
    .in_num(rt_s1), .in_den(rt_st[DENW-1:0]), .in_side(dv_in_side),
    .out_valid(dv_valid), .out_w(dv_w1), .out_side(dv_side)
  );

  qslerp_div #(.SIDE_W(1)) u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(rt_valid),
    .in_num(rt_s2), .in_den(rt_st[DENW-1:0]), .in_side(1'b0),
    .out_valid(), .out_w(dv_w2), .out_side()
  );

  qslerp_mix u_mix (
    .clk(clk), .rst(rst), .en(en), .in_valid(dv_valid),
    .in_w1(dv_w1), .in_w2(dv_w2), .in_side(dv_side),
    .out_valid(m_axis_tvalid), .out_q(out_q)
  );

  assign m_axis_tdata = out_q;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_out_w_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384))
    else $error("out_w outside saturation range");

  a_out_z_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[63:48]) >= -16'sd16384))
    else $error("out_z outside saturation range");

  a_small_angle_linear: assert property (@(posedge clk) disable iff (rst)
    (ang_valid && ang_theta <= $signed({{(ZW-LW){1'b0}}, limit})) |-> ang_side.lin)
    else $error("small angle without linear weights");

endmodule

// ===== sv/qslerp_front.sv =====
module qslerp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  qslerp_pkg::comp_t [3:0]       in_p,
  input  qslerp_pkg::comp_t [3:0]       in_q,
  input  qslerp_pkg::blend_t            in_t,
  output logic                          out_valid,
  output logic [qslerp_pkg::DW-1:0]     out_d30,
  output logic [qslerp_pkg::RW-1:0]     out_rad,
  output qslerp_pkg::side_t             out_side
);
  import qslerp_pkg::*;

  localparam int DSUMW = 2*CW + 2;
  localparam int DSHL  = (2*FRAC >= UNIT) ? 0 : UNIT - 2*FRAC;
  localparam int DSHR  = (2*FRAC >= UNIT) ? 2*FRAC - UNIT : 0;

  logic [3:0]               valid;
  comp_t [3:0]              p1, q1, p2, q2;
  blend_t                   t1, t2;
  logic signed [2*CW-1:0]   prod1 [4];
  logic signed [DSUMW-1:0]  d2;
  logic                     neg;
  logic [63:0]              dmag, dclamp;
  qcomp_t [3:0]             qn;
  side_t                    side3;
  logic [DW-1:0]            dd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[2:0], in_valid};
    end
  end

  always_comb begin
    neg    = d2[DSUMW-1];
    dmag   = neg ? 64'(-d2) : 64'(d2);
    dclamp = (dmag > (64'(1) << (2*FRAC))) ? (64'(1) << (2*FRAC)) : dmag;
    for (int k = 0; k < 4; k++) begin
      qn[k] = neg ? -QW'($signed(q2[k])) : QW'($signed(q2[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= in_p;
      q1 <= in_q;
      t1 <= (in_t > ONE_T) ? ONE_T : in_t;
      for (int k = 0; k < 4; k++) begin
        prod1[k] <= $signed(in_p[k]) * $signed(in_q[k]);
      end
      p2 <= p1;
      q2 <= q1;
      t2 <= t1;
      d2 <= DSUMW'(prod1[0]) + DSUMW'(prod1[1]) + DSUMW'(prod1[2]) + DSUMW'(prod1[3]);
      side3.p   <= p2;
      side3.q   <= qn;
      side3.t   <= t2;
      side3.lin <= 1'b0;
      dd3       <= DW'((dclamp << DSHL) >> DSHR);
      out_rad   <= RW'((64'(1) << (2*UNIT)) - 64'(dd3) * 64'(dd3));
      out_d30   <= dd3;
      out_side  <= side3;
    end
  end

  assign out_valid = valid[3];

endmodule

// ===== sv/qslerp_isqrt.sv =====
module qslerp_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [qslerp_pkg::RW-1:0] in_rad,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [qslerp_pkg::SW-1:0] out_root,
  output logic [SIDE_W-1:0]         out_side
);
  import qslerp_pkg::*;

  localparam int N = SW;

  logic              valid [N+1];
  logic [RW-1:0]     rem   [N+1];
  logic [SW-1:0]     root  [N+1];
  logic [SIDE_W-1:0] side  [N+1];

  assign valid[0] = in_valid;
  assign rem[0]   = in_rad;
  assign root[0]  = '0;
  assign side[0]  = in_side;

  // one result bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [63:0] trial;
    logic        fits;

    assign trial = (64'(root[k]) << (B + 1)) + (64'(1) << (2*B));
    assign fits  = 64'(rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? RW'(64'(rem[k]) - trial) : rem[k];
        root[k+1] <= fits ? (root[k] | (SW'(1) << B)) : root[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = valid[N];
  assign out_root  = root[N];
  assign out_side  = side[N];

endmodule

// ===== sv/qslerp_vec.sv =====
module qslerp_vec #(
  parameter int ITERS  = qslerp_pkg::ANGLE_ITERATIONS,
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [qslerp_pkg::DW-1:0] in_x,
  input  logic [qslerp_pkg::SW-1:0] in_y,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [qslerp_pkg::AW-1:0] out_theta,
  output logic [SIDE_W-1:0]         out_side
);
  import qslerp_pkg::*;

  logic                 valid [ITERS+1];
  logic signed [VW-1:0] x     [ITERS+1];
  logic signed [VW-1:0] y     [ITERS+1];
  logic signed [ZW-1:0] z     [ITERS+1];
  logic [SIDE_W-1:0]    side  [ITERS+1];

  assign valid[0] = in_valid;
  assign x[0]     = VW'(in_x);
  assign y[0]     = VW'(in_y);
  assign z[0]     = '0;
  assign side[0]  = in_side;

  // rotate toward the x axis, accumulating the angle
  for (genvar i = 0; i < ITERS; i++) begin : g_step
    logic signed [VW-1:0] dx, dy;
    logic signed [ZW-1:0] step;
    logic                 up;

    assign dx   = y[i] >>> i;
    assign dy   = x[i] >>> i;
    assign step = $signed(arc_step(i));
    assign up   = y[i] > 0;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]    <= up ? x[i] + dx : x[i] - dx;
        y[i+1]    <= up ? y[i] - dy : y[i] + dy;
        z[i+1]    <= up ? z[i] + step : z[i] - step;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = valid[ITERS];
  assign out_theta = z[ITERS][ZW-1] ? '0 : AW'(z[ITERS]);
  assign out_side  = side[ITERS];

endmodule

// ===== sv/qslerp_rot.sv =====
module qslerp_rot #(
  parameter int ITERS  = qslerp_pkg::ANGLE_ITERATIONS,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [qslerp_pkg::ZW-1:0] in_z,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic signed [qslerp_pkg::VW-1:0] out_y,
  output logic [SIDE_W-1:0]                out_side
);
  import qslerp_pkg::*;

  logic                 valid [ITERS+1];
  logic signed [VW-1:0] x     [ITERS+1];
  logic signed [VW-1:0] y     [ITERS+1];
  logic signed [ZW-1:0] z     [ITERS+1];
  logic [SIDE_W-1:0]    side  [ITERS+1];

  assign valid[0] = in_valid;
  assign x[0]     = VW'(64'(1) << UNIT);
  assign y[0]     = '0;
  assign z[0]     = in_z;
  assign side[0]  = in_side;

  // rotate the unit vector by the angle; the sine is the final y
  for (genvar i = 0; i < ITERS; i++) begin : g_step
    logic signed [VW-1:0] dx, dy;
    logic signed [ZW-1:0] step;
    logic                 ccw;

    assign dx   = y[i] >>> i;
    assign dy   = x[i] >>> i;
    assign step = $signed(arc_step(i));
    assign ccw  = !z[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]    <= ccw ? x[i] - dx : x[i] + dx;
        y[i+1]    <= ccw ? y[i] + dy : y[i] - dy;
        z[i+1]    <= ccw ? z[i] - step : z[i] + step;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = valid[ITERS];
  assign out_y     = y[ITERS];
  assign out_side  = side[ITERS];

endmodule

// ===== sv/qslerp_div.sv =====
module qslerp_div #(
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [qslerp_pkg::VW-1:0] in_num,
  input  logic [qslerp_pkg::DENW-1:0]      in_den,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic signed [qslerp_pkg::WW-1:0] out_w,
  output logic [SIDE_W-1:0]                out_side
);
  import qslerp_pkg::*;

  // quotient of |num| * 2^UNIT / den, one bit per stage
  localparam int QB   = WW;
  localparam int PRE  = QB - UNIT;
  localparam int REMW = DENW + 2;
  localparam logic [QB-1:0] WMAX = QB'(64'(1) << (WW - 2));

  logic              neg_in, ovf_in;
  logic [VW-1:0]     mag_in;

  logic              valid [QB+1];
  logic              neg   [QB+1];
  logic              ovf   [QB+1];
  logic [VW-1:0]     mag   [QB+1];
  logic [DENW-1:0]   den   [QB+1];
  logic [REMW-1:0]   rem   [QB+1];
  logic [QB-1:0]     quo   [QB+1];
  logic [SIDE_W-1:0] side  [QB+1];
  logic              out_valid_r;
  logic [QB-1:0]     qsat;

  always_comb begin
    neg_in = in_num[VW-1];
    mag_in = neg_in ? VW'(-in_num) : VW'(in_num);
    ovf_in = 64'(mag_in >> PRE) >= 64'(in_den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0]  <= neg_in;
      ovf[0]  <= ovf_in;
      mag[0]  <= mag_in;
      den[0]  <= in_den;
      rem[0]  <= REMW'(mag_in >> PRE);
      quo[0]  <= '0;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int J = QB - 1 - k;
    logic              nbit;
    logic [REMW:0]     sh;
    logic              ge;

    if (J >= UNIT) begin : g_bit
      assign nbit = mag[k][J-UNIT];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign sh = {rem[k], nbit};
    assign ge = sh >= (REMW+1)'(den[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? REMW'(sh - (REMW+1)'(den[k])) : REMW'(sh);
        quo[k+1]  <= ge ? (quo[k] | (QB'(1) << J)) : quo[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
        mag[k+1]  <= mag[k];
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign qsat = (ovf[QB] || quo[QB] > WMAX) ? WMAX : quo[QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w    <= neg[QB] ? -$signed(qsat) : $signed(qsat);
      out_side <= side[QB];
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/qslerp_mix.sv =====
module qslerp_mix (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [qslerp_pkg::WW-1:0] in_w1,
  input  logic signed [qslerp_pkg::WW-1:0] in_w2,
  input  qslerp_pkg::side_t                in_side,
  output logic                             out_valid,
  output qslerp_pkg::comp_t [3:0]          out_q
);
  import qslerp_pkg::*;

  localparam int PW = WW + QW;
  localparam logic signed [PW:0] HALF  = (PW+1)'(64'(1) << (UNIT - 1));
  localparam logic signed [PW:0] ONE_W = (PW+1)'(64'(1) << FRAC);

  logic [2:0]            valid;
  logic signed [WW-1:0]  w1s, w2s;
  comp_t [3:0]           p1;
  qcomp_t [3:0]          q1;
  logic signed [PW-1:0]  pa [4];
  logic signed [PW-1:0]  qa [4];
  logic signed [PW:0]    r  [4];
  logic signed [PW:0]    sh [4];
  comp_t [3:0]           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[1:0], in_valid};
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r[k]  = (PW+1)'(pa[k]) + (PW+1)'(qa[k]) + HALF;
      sh[k] = r[k] >>> UNIT;
      if (sh[k] > ONE_W) begin
        res[k] = CW'(ONE_W);
      end else if (sh[k] < -ONE_W) begin
        res[k] = CW'(-ONE_W);
      end else begin
        res[k] = CW'(sh[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1s <= in_side.lin ? WW'((64'(ONE_T) - 64'(in_side.t)) << (UNIT - FRAC)) : in_w1;
      w2s <= in_side.lin ? WW'(64'(in_side.t) << (UNIT - FRAC)) : in_w2;
      p1  <= in_side.p;
      q1  <= in_side.q;
      for (int k = 0; k < 4; k++) begin
        pa[k] <= w1s * $signed(p1[k]);
        qa[k] <= w2s * $signed(q1[k]);
      end
      out_q <= res;
    end
  end

  assign out_valid = valid[2];

endmodule
